@@ rtl/core/ble_pkg.sv @@
package ble_pkg;

  // Capacity of the list and the widths that follow from it.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  // Width wide enough to compare a request position against the length.
  localparam int unsigned PW = (LW > 4) ? LW : 4;

  // Field widths of the stream items.
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FPOS_W   = 4;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT_FRONT = 3'd0,
    KIND_APPEND_BACK  = 3'd1,
    KIND_REMOVE_FRONT = 3'd2,
    KIND_REMOVE_BACK  = 3'd3,
    KIND_REMOVE_AT    = 3'd4,
    KIND_SEARCH       = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_BAD_POS = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  // Maps a list index to a memory address of the circular store.
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
                                              input logic [LW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + (AW+1)'(idx);
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

endpackage

@@ rtl/core/bounded_list_engine.sv @@
// Channel   Direction  Signals                     Contents
// s_axis    in         tvalid tready tdata tuser   tdata: value, position; tuser: kind
// m_axis    out        tvalid tready tdata         tdata: status, found, found_position, length
//
// Insert, append and the two end removals go from acceptance straight to the result state.
// A search starts at the front, a removal at position p at the entry behind p;
// both walk the circular store through its single read port, one entry a cycle.
// Reset empties the list at once; the store itself is not cleared.
// A result waits in the output register while the master side stalls; a new
// request is taken once the previous one has handed its result over.
module bounded_list_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] value, [35:32] position, [39:36] zero
  input  logic [ble_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [2:0] kind
  input  logic [ble_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] status, [2] found, [6:3] found_position, [11:7] length, [15:12] zero
  output logic [ble_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SEARCH,
    ST_RESP
  } state_e;

  localparam int unsigned AW = ble_pkg::AW;
  localparam int unsigned LW = ble_pkg::LW;

  // Storage: one synchronous memory with a registered read port.
  logic [ble_pkg::VALUE_W-1:0] mem [ble_pkg::CAPACITY];
  logic [ble_pkg::VALUE_W-1:0] rd_data_q;
  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [AW-1:0]               mem_ra;
  logic [ble_pkg::VALUE_W-1:0] mem_wd;

  // Control state.
  state_e                       state_q, state_d;
  logic [AW-1:0]                head_q, head_d;
  logic [LW-1:0]                len_q, len_d;
  logic [LW-1:0]                rd_idx_q, rd_idx_d;
  logic [LW-1:0]                wr_idx_q, wr_idx_d;
  logic                         pend_q, pend_d;
  logic [ble_pkg::VALUE_W-1:0]  key_q, key_d;
  logic [ble_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic                         res_found_q, res_found_d;
  logic [AW-1:0]                res_fpos_q, res_fpos_d;
  logic                         out_valid_q, out_valid_d;
  logic [ble_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Request fields.
  logic                         in_accept;
  logic [ble_pkg::VALUE_W-1:0]  in_value;
  logic [ble_pkg::POS_W-1:0]    in_pos;
  logic                         rd_more;
  logic                         is_full;
  logic                         is_empty;

  assign in_value  = s_axis_tdata[ble_pkg::VALUE_W-1:0];
  assign in_pos    = s_axis_tdata[ble_pkg::VALUE_W +: ble_pkg::POS_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign rd_more   = (rd_idx_q < len_q);
  assign is_full   = (len_q == LW'(ble_pkg::CAPACITY));
  assign is_empty  = (len_q == '0);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Next-state logic for the request sequencer and the memory port.
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    len_d        = len_q;
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    pend_d       = pend_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_fpos_d   = res_fpos_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    mem_we       = 1'b0;
    mem_wa       = ble_pkg::phys_addr(head_q, wr_idx_q);
    mem_wd       = rd_data_q;
    mem_ra       = ble_pkg::phys_addr(head_q, rd_idx_q);

    // The master side takes the waiting result.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_status_d = ble_pkg::STATUS_OK;
          res_found_d  = 1'b0;
          res_fpos_d   = '0;
          key_d        = in_value;
          pend_d       = 1'b0;
          state_d      = ST_RESP;
          case (s_axis_tuser)
            ble_pkg::KIND_INSERT_FRONT: begin
              if (is_full) begin
                res_status_d = ble_pkg::STATUS_FULL;
              end else begin
                head_d = (head_q == '0) ? AW'(ble_pkg::CAPACITY - 1) : head_q - 1'b1;
                mem_we = 1'b1;
                mem_wa = head_d;
                mem_wd = in_value;
                len_d  = len_q + 1'b1;
              end
            end
            ble_pkg::KIND_APPEND_BACK: begin
              if (is_full) begin
                res_status_d = ble_pkg::STATUS_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = ble_pkg::phys_addr(head_q, len_q);
                mem_wd = in_value;
                len_d  = len_q + 1'b1;
              end
            end
            ble_pkg::KIND_REMOVE_FRONT: begin
              if (is_empty) begin
                res_status_d = ble_pkg::STATUS_EMPTY;
              end else begin
                head_d = (head_q == AW'(ble_pkg::CAPACITY - 1)) ? '0 : head_q + 1'b1;
                len_d  = len_q - 1'b1;
              end
            end
            ble_pkg::KIND_REMOVE_BACK: begin
              if (is_empty) begin
                res_status_d = ble_pkg::STATUS_EMPTY;
              end else begin
                len_d = len_q - 1'b1;
              end
            end
            ble_pkg::KIND_REMOVE_AT: begin
              if (is_empty) begin
                res_status_d = ble_pkg::STATUS_EMPTY;
              end else if (ble_pkg::PW'(in_pos) >= ble_pkg::PW'(len_q)) begin
                res_status_d = ble_pkg::STATUS_BAD_POS;
              end else begin
                // Move every entry behind the position down by one.
                wr_idx_d = LW'(in_pos);
                rd_idx_d = LW'(in_pos) + 1'b1;
                state_d  = ST_SHIFT;
              end
            end
            ble_pkg::KIND_SEARCH: begin
              if (!is_empty) begin
                rd_idx_d = '0;
                wr_idx_d = '0;
                state_d  = ST_SEARCH;
              end
            end
            default: begin
              res_status_d = ble_pkg::STATUS_BAD_POS;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // Read one entry ahead, write the previous read one slot lower.
        if (rd_more) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        pend_d = rd_more;
        if (pend_q) begin
          mem_we   = 1'b1;
          wr_idx_d = wr_idx_q + 1'b1;
        end
        if (!rd_more && !pend_q) begin
          len_d   = len_q - 1'b1;
          state_d = ST_RESP;
        end
      end

      ST_SEARCH: begin
        // Compare the entry read last cycle; wr_idx_q tracks its index.
        if (rd_more) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        pend_d = rd_more;
        if (pend_q) begin
          wr_idx_d = wr_idx_q + 1'b1;
        end
        if (pend_q && (rd_data_q == key_q)) begin
          res_found_d = 1'b1;
          res_fpos_d  = wr_idx_q[AW-1:0];
          pend_d      = 1'b0;
          state_d     = ST_RESP;
        end else if (!rd_more && !pend_q) begin
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[1:0]  = res_status_q;
          out_data_d[2]    = res_found_q;
          out_data_d[6:3]  = ble_pkg::FPOS_W'(res_fpos_q);
          out_data_d[11:7] = ble_pkg::LEN_W'(len_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      len_q       <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      len_q       <= len_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_fpos_q   <= res_fpos_d;
  end

  // List store: at most one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[mem_ra];
  end

  // The length never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(ble_pkg::CAPACITY))
    else $error("list length above capacity");

  // The length moves by at most one entry per step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != $past(len_q)) |->
      ((len_q == $past(len_q) + 1'b1) || (len_q + 1'b1 == $past(len_q))))
    else $error("list length jumped");

  // A pending walk write or compare always refers to an entry inside the list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && ((state_q == ST_SHIFT) || (state_q == ST_SEARCH))) |->
      (wr_idx_q < len_q))
    else $error("walk index outside the list");

  // The output register is never overwritten while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("waiting result lost");

endmodule

@@ dv/tb_bounded_list_engine.sv @@
`timescale 1ns / 100ps

module tb_bounded_list_engine;

  // Request kinds the block does not define; both must be answered with a bad position.
  localparam logic [ble_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [ble_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  localparam int unsigned MAX_GAP        = 19;
  localparam int unsigned HOLD_OFF       = 250;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  typedef struct packed {
    ble_pkg::status_e             status;
    logic                         found;
    logic [ble_pkg::FPOS_W-1:0]   fpos;
    logic [ble_pkg::LEN_W-1:0]    length;
  } list_result_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [ble_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;
  logic [ble_pkg::KIND_W-1:0]       s_axis_tuser  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [ble_pkg::OUT_DATA_W-1:0]   m_axis_tdata;

  // Shadow copy of the list, updated as each request transaction is accepted.
  logic [ble_pkg::VALUE_W-1:0]      list_shadow [ble_pkg::CAPACITY];
  int unsigned                      shadow_len = 0;
  list_result_t                     pending_results [$];

  int unsigned             mismatch_count = 0;
  int unsigned             quiet_cycles = 0;
  bit                      gaps_on = 1'b1;
  bit                      hold_req = 1'b0;

  bounded_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Applies one request to the shadow list and returns the result it must produce.
  function automatic list_result_t apply_list_op(input logic [ble_pkg::KIND_W-1:0] kind,
                                                 input logic [ble_pkg::VALUE_W-1:0] value,
                                                 input logic [ble_pkg::POS_W-1:0] pos);
    list_result_t res;
    int unsigned  i;
    res.status = ble_pkg::STATUS_OK;
    res.found  = 1'b0;
    res.fpos   = '0;
    case (kind)
      ble_pkg::KIND_INSERT_FRONT: begin
        if (shadow_len >= ble_pkg::CAPACITY) begin
          res.status = ble_pkg::STATUS_FULL;
        end else begin
          for (i = shadow_len; i > 0; i--) list_shadow[i] = list_shadow[i-1];
          list_shadow[0] = value;
          shadow_len++;
        end
      end
      ble_pkg::KIND_APPEND_BACK: begin
        if (shadow_len >= ble_pkg::CAPACITY) begin
          res.status = ble_pkg::STATUS_FULL;
        end else begin
          list_shadow[shadow_len] = value;
          shadow_len++;
        end
      end
      ble_pkg::KIND_REMOVE_FRONT: begin
        if (shadow_len == 0) begin
          res.status = ble_pkg::STATUS_EMPTY;
        end else begin
          for (i = 0; i + 1 < shadow_len; i++) list_shadow[i] = list_shadow[i+1];
          shadow_len--;
        end
      end
      ble_pkg::KIND_REMOVE_BACK: begin
        if (shadow_len == 0) res.status = ble_pkg::STATUS_EMPTY;
        else shadow_len--;
      end
      ble_pkg::KIND_REMOVE_AT: begin
        if (shadow_len == 0) begin
          res.status = ble_pkg::STATUS_EMPTY;
        end else if (pos >= shadow_len) begin
          res.status = ble_pkg::STATUS_BAD_POS;
        end else begin
          for (i = pos; i + 1 < shadow_len; i++) list_shadow[i] = list_shadow[i+1];
          shadow_len--;
        end
      end
      ble_pkg::KIND_SEARCH: begin
        // Only the first match counts.
        for (i = 0; i < shadow_len; i++) begin
          if (!res.found && list_shadow[i] == value) begin
            res.found = 1'b1;
            res.fpos  = ble_pkg::FPOS_W'(i);
          end
        end
      end
      default: begin
        res.status = ble_pkg::STATUS_BAD_POS;
      end
    endcase
    res.length = ble_pkg::LEN_W'(shadow_len);
    return res;
  endfunction

  // Values lean toward extremes and a tiny range, so duplicates and matches are common.
  function automatic logic [ble_pkg::VALUE_W-1:0] pick_value();
    logic [ble_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2, 3, 4: v = 32'($urandom_range(0, 3)) - 32'd2;
      5, 6:    v = (shadow_len > 0) ? list_shadow[$urandom_range(0, shadow_len - 1)]
                                    : $urandom;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Positions mostly fall inside the list, the rest anywhere in the field.
  function automatic logic [ble_pkg::POS_W-1:0] pick_position();
    if (shadow_len > 0 && $urandom_range(0, 4) != 0) begin
      return ble_pkg::POS_W'($urandom_range(0, shadow_len - 1));
    end
    return ble_pkg::POS_W'($urandom_range(0, 15));
  endfunction

  // Offers one request and records its expected result once the transaction is accepted.
  task automatic send_request(input logic [ble_pkg::KIND_W-1:0] kind,
                              input logic [ble_pkg::VALUE_W-1:0] value,
                              input logic [ble_pkg::POS_W-1:0] pos);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, pos, value};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_list_op(kind, value, pos));
  endtask

  // Draws one request; grow_pct sets how often it adds an entry.
  task automatic send_random_op(input int unsigned grow_pct);
    logic [ble_pkg::KIND_W-1:0] kind;
    if ($urandom_range(0, 99) < 3) begin
      kind = $urandom_range(0, 1) ? KIND_UNUSED_HI : KIND_UNUSED_LO;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      kind = $urandom_range(0, 1) ? ble_pkg::KIND_APPEND_BACK : ble_pkg::KIND_INSERT_FRONT;
    end else begin
      case ($urandom_range(0, 3))
        0:       kind = ble_pkg::KIND_REMOVE_FRONT;
        1:       kind = ble_pkg::KIND_REMOVE_BACK;
        2:       kind = ble_pkg::KIND_REMOVE_AT;
        default: kind = ble_pkg::KIND_SEARCH;
      endcase
    end
    send_request(kind, pick_value(), pick_position());
  endtask

  // Removals, searches and undefined kinds on an empty list.
  task automatic test_empty_list();
    send_request(ble_pkg::KIND_REMOVE_FRONT, 32'h0, 4'd0);
    send_request(ble_pkg::KIND_REMOVE_BACK, 32'hFFFF_FFFF, 4'd15);
    send_request(ble_pkg::KIND_REMOVE_AT, 32'h0, 4'd0);
    send_request(ble_pkg::KIND_REMOVE_AT, 32'h0, 4'd15);
    send_request(ble_pkg::KIND_SEARCH, 32'h0, 4'd0);
    send_request(KIND_UNUSED_LO, 32'h1234_5678, 4'd3);
    send_request(KIND_UNUSED_HI, 32'hFFFF_FFFF, 4'd15);
  endtask

  // Every operation with extreme values, duplicates and out-of-range positions.
  task automatic test_basic_ops();
    send_request(ble_pkg::KIND_INSERT_FRONT, 32'h7FFF_FFFF, 4'd0);
    send_request(ble_pkg::KIND_APPEND_BACK, 32'h8000_0000, 4'd15);
    send_request(ble_pkg::KIND_INSERT_FRONT, 32'h0, 4'd0);
    send_request(ble_pkg::KIND_APPEND_BACK, 32'hFFFF_FFFF, 4'd0);
    send_request(ble_pkg::KIND_APPEND_BACK, 32'h0, 4'd0);
    send_request(ble_pkg::KIND_SEARCH, 32'hFFFF_FFFF, 4'd0);
    send_request(ble_pkg::KIND_SEARCH, 32'h0, 4'd15);
    send_request(ble_pkg::KIND_SEARCH, 32'h8000_0000, 4'd0);
    send_request(ble_pkg::KIND_SEARCH, 32'd12345, 4'd0);
    send_request(ble_pkg::KIND_REMOVE_AT, 32'h0, 4'd5);
    send_request(ble_pkg::KIND_REMOVE_AT, 32'h0, 4'd15);
    send_request(ble_pkg::KIND_REMOVE_AT, 32'h0, 4'd2);
    send_request(ble_pkg::KIND_REMOVE_AT, 32'h0, 4'd3);
    send_request(ble_pkg::KIND_REMOVE_FRONT, 32'h0, 4'd0);
    send_request(ble_pkg::KIND_REMOVE_BACK, 32'h0, 4'd0);
    send_request(ble_pkg::KIND_REMOVE_AT, 32'h0, 4'd0);
    send_request(ble_pkg::KIND_SEARCH, 32'h7FFF_FFFF, 4'd0);
  endtask

  // Fills to capacity, pushes against full, drains empty, removes on empty; three rounds.
  task automatic test_fill_drain();
    repeat (3) begin
      while (shadow_len < ble_pkg::CAPACITY) begin
        send_request($urandom_range(0, 1) ? ble_pkg::KIND_APPEND_BACK
                                          : ble_pkg::KIND_INSERT_FRONT,
                     pick_value(), pick_position());
      end
      send_request(ble_pkg::KIND_INSERT_FRONT, pick_value(), pick_position());
      send_request(ble_pkg::KIND_APPEND_BACK, pick_value(), pick_position());
      send_request(ble_pkg::KIND_SEARCH,
                   list_shadow[$urandom_range(0, ble_pkg::CAPACITY - 1)], 4'd0);
      send_request(ble_pkg::KIND_SEARCH, $urandom, pick_position());
      send_request(ble_pkg::KIND_REMOVE_AT, pick_value(), 4'd15);
      while (shadow_len > 0) begin
        case ($urandom_range(0, 4))
          0:       send_request(ble_pkg::KIND_REMOVE_FRONT, pick_value(), pick_position());
          1:       send_request(ble_pkg::KIND_REMOVE_BACK, pick_value(), pick_position());
          2:       send_request(ble_pkg::KIND_SEARCH, pick_value(), pick_position());
          default: send_request(ble_pkg::KIND_REMOVE_AT, pick_value(), pick_position());
        endcase
      end
      send_request(ble_pkg::KIND_REMOVE_FRONT, pick_value(), pick_position());
      send_request(ble_pkg::KIND_REMOVE_AT, pick_value(), pick_position());
    end
  endtask

  // The result side holds off for a long stretch while requests keep coming back to back.
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_random_op(60);
    gaps_on  = 1'b1;
  endtask

  // A stretch with no idle cycles on either side.
  task automatic test_no_idle();
    gaps_on = 1'b0;
    repeat (3) begin
      repeat (25) send_random_op(70);
      repeat (15) send_random_op(25);
    end
    gaps_on = 1'b1;
  endtask

  // Long random mix that alternates between growing and shrinking the list.
  task automatic test_random_mix();
    repeat (6) begin
      repeat (45) send_random_op(70);
      repeat (40) send_random_op(25);
    end
  endtask

  // Result sink: random stalls per result, plus the long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compares each accepted result transaction with the oldest expected result.
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    list_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = ble_pkg::status_e'(m_axis_tdata[1:0]);
      got.found  = m_axis_tdata[2];
      got.fpos   = m_axis_tdata[6:3];
      got.length = m_axis_tdata[11:7];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, tdata %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          mismatch_count++;
        end
        if (got.found != want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
          mismatch_count++;
        end
        if (got.fpos != want.fpos) begin
          $display("%0t: found_position expected %0d actual %0d", $time, want.fpos, got.fpos);
          mismatch_count++;
        end
        if (got.length != want.length) begin
          $display("%0t: length expected %0d actual %0d", $time, want.length, got.length);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if neither side moves a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_basic_ops();
    test_fill_drain();
    test_backpressure();
    test_no_idle();
    test_random_mix();
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ble_pkg.sv
rtl/core/bounded_list_engine.sv
dv/tb_bounded_list_engine.sv
